// ===== sv/box_blur_3x3_edge_clipped_unit_defines.svh =====
// Assertion macros for the 3x3 box blur unit.
// Used by the top level; expects clk and rst_n in scope where expanded.
`ifndef BOX_BLUR_3X3_EDGE_CLIPPED_UNIT_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_CLIPPED_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BB3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bb3_pkg.sv =====
// Package for the 3x3 box blur unit: payload structs, codes, controller
// commands and the small-divisor rounding function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

    // Field widths.
    localparam int COLOR_W        = 8;
    localparam int SUM_W          = 12;
    localparam int COUNT_W        = 4;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int RECIP_W        = 17;
    localparam int RECIP_SHIFT    = 17;
    localparam int PROD_W         = 30;

    // Register reset values.
    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Item opcodes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic               op;
        logic [COLOR_W-1:0] red_in;
        logic [COLOR_W-1:0] green_in;
        logic [COLOR_W-1:0] blue_in;
    } pix_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] blue_out;
        logic               frame_last;
    } res_t;

    // One stored RGB pixel; blue in the low byte.
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_DIV
    } bb3_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               capture;
        logic               load;
        logic               sum_en;
        logic               clear_win;
        logic               out_load;
        logic               frame_last;
        logic               use_top;
        logic               use_bottom;
        logic               use_left;
        logic               use_right;
        logic [COUNT_W-1:0] count;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } dp_sts_t;

    // Scaled reciprocal of 2*n, rounded up, for the divisors that can occur.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [COUNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            COUNT_W'(1): m = RECIP_W'(65536);
            COUNT_W'(2): m = RECIP_W'(32768);
            COUNT_W'(3): m = RECIP_W'(21846);
            COUNT_W'(4): m = RECIP_W'(16384);
            COUNT_W'(6): m = RECIP_W'(10923);
            COUNT_W'(9): m = RECIP_W'(7282);
            default:     m = '0;
        endcase
        return m;
    endfunction

    // Mean rounded half up: floor((2*sum + n) / (2*n)), by reciprocal multiply.
    // The reciprocal error times the largest dividend stays below 2^17, so
    // the quotient is exact.
    function automatic logic [COLOR_W-1:0] round_mean(input logic [SUM_W-1:0] sum,
                                                     input logic [COUNT_W-1:0] n);
        logic [SUM_W:0]    dividend;
        logic [PROD_W-1:0] prod;
        dividend = {sum, 1'b0} + (SUM_W + 1)'(n);
        prod     = PROD_W'(dividend) * PROD_W'(recip_of(n));
        return prod[RECIP_SHIFT +: COLOR_W];
    endfunction

endpackage

`default_nettype wire

// ===== sv/bb3_ctrl.sv =====
// Controller of the 3x3 box blur: frame registers, stream position,
// window geometry and the per-item state machine. Depends on bb3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bb3_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               pix_valid,
    input  wire                               pix_op,
    output logic                              pix_ready,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [bb3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [bb3_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  bb3_pkg::dp_sts_t                  sts,
    output bb3_pkg::ctl_cmd_t                 cmd,
    output logic [CW-1:0]                     rd_addr
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam logic [WW-1:0] WIDTH_RST =
        WW'((bb3_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                     : bb3_pkg::FRAME_WIDTH_RESET);
    localparam logic [HW-1:0] HEIGHT_RST =
        HW'((bb3_pkg::FRAME_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                       : bb3_pkg::FRAME_HEIGHT_RESET);

    // Neighborhood geometry of the result that an item produces.
    typedef struct packed {
        logic have;
        logic last;
        logic top;
        logic bottom;
        logic left;
        logic right;
    } geom_t;

    bb3_pkg::bb3_state_t state_reg, state_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [WW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;
    geom_t         geom_reg, geom_next;

    geom_t         geom_new;
    logic          accept;
    logic          start;
    logic          pixel_phase;
    logic          col0;
    logic          res_a;
    logic          res_b;
    logic [RW-1:0] row_h;
    logic [WW-1:0] col_inc;
    logic          cfg_restart;
    logic [1:0]    rows;
    logic [1:0]    cols;
    logic [bb3_pkg::FRAME_WIDTH_W-1:0]  fw;
    logic [bb3_pkg::FRAME_HEIGHT_W-1:0] fh;

    // Classify the offered item against the current stream position.
    // A pending register write goes first, so an item waits while it is offered.
    always_comb
    begin
        accept      = pix_valid && !cfg_valid && (state_reg == bb3_pkg::ST_IDLE);
        row_h       = RW'(height_reg);
        pixel_phase = row_reg < row_h;
        start       = accept && ((pix_op == bb3_pkg::OP_PIXEL) == pixel_phase);
        col0        = (col_reg == '0);
        // First column: finish the last pixel of the row two back.
        res_a       = col0 && (32'(row_reg) >= 32'd2);
        // Other columns: the pixel one row up and one column left.
        res_b       = !col0 && (row_reg != '0);
        geom_new.have   = res_a || res_b;
        geom_new.last   = res_a && (row_reg == row_h + RW'(1));
        geom_new.top    = res_a ? (32'(row_reg) >= 32'd3) : (32'(row_reg) >= 32'd2);
        geom_new.bottom = res_a ? (row_reg <= row_h) : (row_reg < row_h);
        geom_new.left   = res_a ? (32'(width_reg) >= 32'd2) : (32'(col_reg) >= 32'd2);
        geom_new.right  = res_b;
        geom_next       = start ? geom_new : geom_reg;
    end

    // Frame register writes: saturate to the supported range, restart the frame.
    always_comb
    begin
        fw          = cfg_data[bb3_pkg::FRAME_WIDTH_W-1:0];
        fh          = cfg_data[bb3_pkg::FRAME_HEIGHT_W-1:0];
        width_next  = width_reg;
        height_next = height_reg;
        cfg_restart = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bb3_pkg::REG_FRAME_WIDTH:
                begin
                    if (fw == '0)
                        width_next = WW'(1);
                    else if (32'(fw) > 32'(MAX_WIDTH))
                        width_next = WW'(MAX_WIDTH);
                    else
                        width_next = WW'(fw);
                    cfg_restart = 1'b1;
                end
                bb3_pkg::REG_FRAME_HEIGHT:
                begin
                    if (fh == '0)
                        height_next = HW'(1);
                    else if (32'(fh) > 32'(MAX_HEIGHT))
                        height_next = HW'(MAX_HEIGHT);
                    else
                        height_next = HW'(fh);
                    cfg_restart = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Stream position: advance on each item that takes effect.
    always_comb
    begin
        col_inc  = WW'(col_reg) + WW'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (start)
        begin
            if (geom_new.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= width_reg)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bb3_pkg::ST_IDLE:
                if (start)
                    state_next = bb3_pkg::ST_LOAD;
            bb3_pkg::ST_LOAD:
                state_next = geom_reg.have ? bb3_pkg::ST_SUM : bb3_pkg::ST_IDLE;
            bb3_pkg::ST_SUM:
                state_next = bb3_pkg::ST_DIV;
            bb3_pkg::ST_DIV:
                if (sts.out_free)
                    state_next = bb3_pkg::ST_IDLE;
            default:
                state_next = bb3_pkg::ST_IDLE;
        endcase
    end

    // State machine outputs and datapath commands.
    always_comb
    begin
        rows           = 2'd1 + {1'b0, geom_reg.top} + {1'b0, geom_reg.bottom};
        cols           = 2'd1 + {1'b0, geom_reg.left} + {1'b0, geom_reg.right};
        pix_ready      = 1'b0;
        cfg_ready      = 1'b0;
        cmd            = '0;
        cmd.frame_last = geom_reg.last;
        cmd.use_top    = geom_reg.top;
        cmd.use_bottom = geom_reg.bottom;
        cmd.use_left   = geom_reg.left;
        cmd.use_right  = geom_reg.right;
        cmd.count      = {2'b00, rows} * {2'b00, cols};
        cmd.clear_win  = cfg_restart;
        case (state_reg)
            bb3_pkg::ST_IDLE:
            begin
                pix_ready   = !cfg_valid;
                cfg_ready   = 1'b1;
                cmd.capture = start;
            end
            bb3_pkg::ST_LOAD:
                cmd.load = 1'b1;
            bb3_pkg::ST_SUM:
            begin
                cmd.sum_en    = 1'b1;
                cmd.clear_win = geom_reg.last;
            end
            bb3_pkg::ST_DIV:
                cmd.out_load = sts.out_free;
            default:
            begin
            end
        endcase
    end

    assign rd_addr = col_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bb3_pkg::ST_IDLE;
            col_reg    <= '0;
            row_reg    <= '0;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            geom_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            geom_reg   <= geom_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bb3_datapath.sv =====
// Datapath of the 3x3 box blur: two line stores, the 3x3 window, the
// neighborhood sums and the rounded divide into the output register. Depends on bb3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bb3_datapath #(
    parameter int MAX_WIDTH = 1024,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  bb3_pkg::ctl_cmd_t       cmd,
    input  wire  [CW-1:0]           rd_addr,
    input  bb3_pkg::pix_t           pix,
    output bb3_pkg::res_t           res,
    output logic                    res_valid,
    input  wire                     res_ready,
    output bb3_pkg::dp_sts_t        sts
);

    // Line stores: the two rows above the incoming one.
    bb3_pkg::rgb_t upper_mem  [MAX_WIDTH];
    bb3_pkg::rgb_t middle_mem [MAX_WIDTH];

    bb3_pkg::rgb_t up_rd_reg;
    bb3_pkg::rgb_t mid_rd_reg;
    bb3_pkg::rgb_t pix_reg;
    bb3_pkg::rgb_t pix_next;
    logic          wr_pend_reg;
    logic [CW-1:0] addr_reg;

    // Window entry index is column * 3 + row; column 2 is the newest.
    bb3_pkg::rgb_t win_reg  [9];
    bb3_pkg::rgb_t win_next [9];

    logic [bb3_pkg::SUM_W-1:0]   sum_reg  [3];
    logic [bb3_pkg::SUM_W-1:0]   sum_next [3];
    logic [bb3_pkg::COUNT_W-1:0] count_reg;
    bb3_pkg::res_t               res_reg;
    bb3_pkg::res_t               res_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    // A drain tick shifts in a blank pixel.
    always_comb
    begin
        if (pix.op == bb3_pkg::OP_PIXEL)
            pix_next = '{red: pix.red_in, green: pix.green_in, blue: pix.blue_in};
        else
            pix_next = '0;
    end

    // Line-store read on transfer, write back of the shifted rows in the next cycle (pixels only).
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            up_rd_reg   <= upper_mem[rd_addr];
            mid_rd_reg  <= middle_mem[rd_addr];
            addr_reg    <= rd_addr;
            pix_reg     <= pix_next;
            wr_pend_reg <= (pix.op == bb3_pkg::OP_PIXEL);
        end
        if (cmd.load && wr_pend_reg)
        begin
            upper_mem[addr_reg]  <= mid_rd_reg;
            middle_mem[addr_reg] <= pix_reg;
        end
    end

    // Window shift by one column, or clear on a frame restart or at frame end.
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            win_next[i] = win_reg[i];
        if (cmd.clear_win)
        begin
            for (int i = 0; i < 9; i++)
                win_next[i] = '0;
        end
        else if (cmd.load)
        begin
            for (int i = 0; i < 6; i++)
                win_next[i] = win_reg[i + 3];
            win_next[6] = up_rd_reg;
            win_next[7] = mid_rd_reg;
            win_next[8] = pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= win_next[i];
        end
    end

    // Masked neighborhood sum per color around window column 1.
    always_comb
    begin
        logic [2:0]                use_col;
        logic [2:0]                use_row;
        logic [23:0]               bits;
        logic [bb3_pkg::SUM_W-1:0] acc;
        use_col = {cmd.use_right, 1'b1, cmd.use_left};
        use_row = {cmd.use_bottom, 1'b1, cmd.use_top};
        for (int c = 0; c < 3; c++)
        begin
            acc = '0;
            for (int col = 0; col < 3; col++)
            begin
                for (int row = 0; row < 3; row++)
                begin
                    bits = win_reg[col * 3 + row];
                    if (use_col[col] && use_row[row])
                        acc = acc + bb3_pkg::SUM_W'(bits[c * bb3_pkg::COLOR_W +: bb3_pkg::COLOR_W]);
                end
            end
            sum_next[c] = acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            for (int c = 0; c < 3; c++)
                sum_reg[c] <= sum_next[c];
            count_reg <= cmd.count;
        end
    end

    // Rounded divide into the output register; sum index 2 is red, 0 is blue.
    always_comb
    begin
        res_next.red_out    = bb3_pkg::round_mean(sum_reg[2], count_reg);
        res_next.green_out  = bb3_pkg::round_mean(sum_reg[1], count_reg);
        res_next.blue_out   = bb3_pkg::round_mean(sum_reg[0], count_reg);
        res_next.frame_last = cmd.frame_last;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            res_reg <= res_next;
    end

    // Output valid: set on load, cleared when the result transfers.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (res_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign res          = res_reg;
    assign res_valid    = out_valid_reg;
    assign sts.out_free = !out_valid_reg || res_ready;

endmodule

`default_nettype wire

// ===== sv/box_blur_3x3_edge_clipped_unit.sv =====
// 3x3 edge-clipped box blur for a raster stream of RGB pixels: each pixel
// becomes the rounded-half-up mean of its in-frame 3x3 neighborhood, per
// color. A result trails its pixel by one row plus one pixel; after the last
// pixel of a frame, frame_width + 1 drain items flush the tail, and the final
// result carries frame_last. Items are handled one at a time: an item that
// produces a result goes through line-store read, window shift and store
// write back, neighborhood sum, and divide into the output register; one
// that produces none ends after the window shift, and an item out of phase
// (a drain tick while pixels are expected or a pixel while draining) is
// taken and dropped. The single-port line stores are read before they are
// written back. The output register lets the next item start while a
// result waits. Line stores need no clearing after reset. Configuration
// writes are taken while no item is in progress and go ahead of an item
// offered in the same cycle; a frame register write restarts the frame.
// Depends on bb3_pkg, bb3_ctrl, bb3_datapath and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_3x3_edge_clipped_unit_defines.svh"

module box_blur_3x3_edge_clipped_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             pix_valid,
    output logic                            pix_ready,
    input  bb3_pkg::pix_t                   pix,
    output logic                            res_valid,
    input  wire                             res_ready,
    output bb3_pkg::res_t                   res,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [bb3_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    bb3_pkg::ctl_cmd_t cmd;
    bb3_pkg::dp_sts_t  sts;
    logic [CW-1:0]     rd_addr;

    // Controller: position, geometry and sequencing.
    bb3_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_op    (pix.op),
        .pix_ready (pix_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    // Datapath: line stores, window, sums and divide.
    bb3_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .pix       (pix),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .sts       (sts)
    );

    // A result is never loaded over one that has not yet transferred.
    `BB3_ASSERT_NOW(a_load_into_free_output, cmd.out_load, sts.out_free, "result loaded over a pending result")
    // The line-store read of an item is always followed by its window shift.
    `BB3_ASSERT_NEXT(a_capture_then_load, cmd.capture, cmd.load, "capture not followed by window load")
    // A loaded result is offered in the next cycle.
    `BB3_ASSERT_NEXT(a_load_shows_valid, cmd.out_load, res_valid, "loaded result not offered")

endmodule

`default_nettype wire
